// ----- src/sorted_address_region_table_assert.svh -----
// Assertion macros for the sorted address region table.
// Used by srt_ctrl; expects signals clk and rst in scope.
`ifndef SORTED_ADDRESS_REGION_TABLE_ASSERT_SVH
`define SORTED_ADDRESS_REGION_TABLE_ASSERT_SVH

// Same-cycle implication.
`define SRT_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication.
`define SRT_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ----- src/srt_pkg.sv -----
// Shared types and constants for the sorted address region table.
// No dependencies.
package srt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int RANK_W      = SLOT_W;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    K_INSERT  = 3'd0,
    K_REMOVE  = 3'd1,
    K_CONTAIN = 3'd2,
    K_OVERLAP = 3'd3,
    K_OFFSET  = 3'd4,
    K_CLEAR   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WALK = 2'd1,
    S_FIN  = 2'd2
  } state_t;

  // Query held for the whole operation, seen by every cell.
  typedef struct packed {
    kind_t              kind;
    logic [63:0]        addr;
    logic [63:0]        ins_end;
    logic [63:0]        query_end;
    logic [63:0]        offset;
    logic               rm_ok;
    logic [SLOT_W-1:0]  rm_slot;
  } query_t;

  // Token walking down the cell chain, one cell per cycle.
  typedef struct packed {
    logic               live;
    logic               hit;
    logic [RANK_W-1:0]  rank;
    logic [SLOT_W-1:0]  slot;
    logic [63:0]        r_start;
    logic [63:0]        r_end;
    logic [63:0]        r_offset;
    logic               free_found;
    logic [SLOT_W-1:0]  free_slot;
    logic [CNT_W-1:0]   pos;
  } token_t;

  // State change broadcast to all cells at the end of an item.
  typedef struct packed {
    logic               do_insert;
    logic               do_remove;
    logic               do_clear;
    logic [RANK_W-1:0]  pos;
    logic [RANK_W-1:0]  rank;
    logic [SLOT_W-1:0]  slot;
  } commit_t;

endpackage

// ----- src/srt_in_if.sv -----
// Request channel of the sorted address region table.
// Standalone; no package needed.
interface srt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [63:0] addr;
  logic [63:0] length;
  logic [63:0] query_end;
  logic [63:0] region_offset_in;
  logic [3:0]  slot_in;

  modport source (output valid, kind, addr, length, query_end, region_offset_in, slot_in,
                  input ready);
  modport sink   (input valid, kind, addr, length, query_end, region_offset_in, slot_in,
                  output ready);
endinterface

// ----- src/srt_out_if.sv -----
// Response channel of the sorted address region table.
// Standalone; no package needed.
interface srt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [3:0]  slot_out;
  logic [63:0] region_start;
  logic [63:0] region_end;
  logic [63:0] region_offset_out;

  modport source (output valid, status, slot_out, region_start, region_end,
                  region_offset_out, input ready);
  modport sink   (input valid, status, slot_out, region_start, region_end,
                  region_offset_out, output ready);
endinterface

// ----- src/srt_cell.sv -----
// One table slot: holds a region and its rank, folds itself into the passing token.
// Depends on srt_pkg.
module srt_cell
  import srt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [SLOT_W-1:0] idx,
  input  query_t            q,
  input  commit_t           c,
  input  token_t            tok_in,
  output token_t            tok_out
);

  logic              v;
  logic [63:0]       start;
  logic [63:0]       stop;
  logic [63:0]       offset;
  logic [RANK_W-1:0] rank;

  token_t tok_next;
  logic   match;

  always_comb begin
    tok_next = tok_in;
    match    = 1'b0;
    case (q.kind)
      K_INSERT: begin
        if (!v && !tok_in.free_found) begin
          tok_next.free_found = 1'b1;
          tok_next.free_slot  = idx;
        end
        if (v && start < q.addr) begin
          tok_next.pos = tok_in.pos + CNT_W'(1);
        end
      end
      K_REMOVE:  match = v && q.rm_ok && (idx == q.rm_slot);
      K_CONTAIN: match = v && (q.addr >= start) && (q.addr < stop);
      K_OVERLAP: match = v && (q.addr < stop) && (q.query_end > start);
      K_OFFSET:  match = v && (offset == q.offset);
      default:   match = 1'b0;
    endcase
    // lowest rank wins; ranks of valid slots are distinct
    if (match && (!tok_in.hit || rank < tok_in.rank)) begin
      tok_next.hit      = 1'b1;
      tok_next.rank     = rank;
      tok_next.slot     = idx;
      tok_next.r_start  = start;
      tok_next.r_end    = stop;
      tok_next.r_offset = offset;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.live <= 1'b0;
    end else begin
      tok_out.live <= tok_in.live;
    end
    tok_out.hit        <= tok_next.hit;
    tok_out.rank       <= tok_next.rank;
    tok_out.slot       <= tok_next.slot;
    tok_out.r_start    <= tok_next.r_start;
    tok_out.r_end      <= tok_next.r_end;
    tok_out.r_offset   <= tok_next.r_offset;
    tok_out.free_found <= tok_next.free_found;
    tok_out.free_slot  <= tok_next.free_slot;
    tok_out.pos        <= tok_next.pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (c.do_clear) begin
      v <= 1'b0;
    end else if (c.do_insert && idx == c.slot) begin
      v <= 1'b1;
    end else if (c.do_remove && idx == c.slot) begin
      v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c.do_insert) begin
      if (idx == c.slot) begin
        start  <= q.addr;
        stop   <= q.ins_end;
        offset <= q.offset;
        rank   <= c.pos;
      end else if (v && rank >= c.pos) begin
        rank <= rank + RANK_W'(1);
      end
    end else if (c.do_remove) begin
      if (v && rank > c.rank) begin
        rank <= rank - RANK_W'(1);
      end
    end
  end

endmodule

// ----- src/srt_ctrl.sv -----
// Sequencer: takes a request, launches the token, commits the change, drives the response.
// Depends on srt_pkg, srt_in_if, srt_out_if and the assertion macro header.
`include "sorted_address_region_table_assert.svh"

module srt_ctrl
  import srt_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  srt_in_if.sink    req,
  srt_out_if.source rsp,
  input  token_t tok_last,
  output token_t tok_first,
  output query_t q,
  output commit_t c
);

  state_t state, state_next;
  logic   start;
  token_t fin;
  logic   accept;
  logic   can_load;
  logic   finish;

  logic        out_valid;
  status_t     out_status;
  logic [3:0]  out_slot;
  logic [63:0] out_start;
  logic [63:0] out_end;
  logic [63:0] out_offset;

  status_t     res_status;
  logic [3:0]  res_slot;
  logic [63:0] res_start;
  logic [63:0] res_end;
  logic [63:0] res_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    finish     = 1'b0;
    can_load   = !out_valid || rsp.ready;
    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (tok_last.live) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (can_load) begin
          finish     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign accept = req.valid && req.ready;

  always_comb begin
    tok_first      = '0;
    tok_first.live = start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      start <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q.kind      <= kind_t'(req.kind);
      q.addr      <= req.addr;
      q.ins_end   <= req.addr + req.length;
      q.query_end <= req.query_end;
      q.offset    <= req.region_offset_in;
      q.rm_ok     <= (32'(req.slot_in) < TABLE_DEPTH);
      q.rm_slot   <= SLOT_W'(req.slot_in);
    end
    if (state == S_WALK && tok_last.live) begin
      fin <= tok_last;
    end
  end

  always_comb begin
    c          = '0;
    res_status = ST_NONE;
    res_slot   = '0;
    res_start  = '0;
    res_end    = '0;
    res_offset = '0;
    case (q.kind)
      K_INSERT: begin
        if (fin.free_found) begin
          c.do_insert = finish;
          res_status  = ST_OK;
          res_slot    = 4'(fin.free_slot);
          res_start   = q.addr;
          res_end     = q.ins_end;
          res_offset  = q.offset;
        end else begin
          res_status = ST_FULL;
        end
      end
      K_REMOVE, K_CONTAIN, K_OVERLAP, K_OFFSET: begin
        if (fin.hit) begin
          c.do_remove = finish && (q.kind == K_REMOVE);
          res_status  = ST_OK;
          res_slot    = 4'(fin.slot);
          res_start   = fin.r_start;
          res_end     = fin.r_end;
          res_offset  = fin.r_offset;
        end
      end
      K_CLEAR: begin
        c.do_clear = finish;
        res_status = ST_OK;
      end
      default: res_status = ST_NONE;
    endcase
    c.pos  = RANK_W'(fin.pos);
    c.rank = fin.rank;
    c.slot = (q.kind == K_INSERT) ? fin.free_slot : fin.slot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_start  <= res_start;
      out_end    <= res_end;
      out_offset <= res_offset;
    end
  end

  assign rsp.valid             = out_valid;
  assign rsp.status            = out_status;
  assign rsp.slot_out          = out_slot;
  assign rsp.region_start      = out_start;
  assign rsp.region_end        = out_end;
  assign rsp.region_offset_out = out_offset;

  `SRT_ASSERT_NOW(a_tok_in_walk, tok_last.live, state == S_WALK, "token left chain outside walk")
  `SRT_ASSERT_NOW(a_commit_room, finish, !out_valid || rsp.ready, "commit with full output")
  `SRT_ASSERT_NEXT(a_launch, accept, start && state == S_WALK, "token not launched")
  `SRT_ASSERT_NOW(a_one_change, finish, $countones({c.do_insert, c.do_remove, c.do_clear}) <= 1, "several changes at once")
  `SRT_ASSERT_NOW(a_rsp_from_fin, $rose(out_valid), $past(state) == S_FIN, "response without commit")

endmodule

// ----- src/sorted_address_region_table.sv -----
// Sorted address region table: sequencer plus a chain of one cell per slot.
// Depends on srt_pkg, srt_in_if, srt_out_if, srt_cell and srt_ctrl.
//
// Usage:
//   req carries one operation per item (insert, remove, find containing,
//   find overlap, find offset, clear); rsp returns exactly one item for each.
//   Handshake on both channels: an item moves when valid and ready are high.
//   A request is taken only while the table is idle. After acceptance a token
//   walks the slot chain one cell per cycle, gathering the lowest free slot,
//   the insert position and the best match by rank. The state change is then
//   applied to all cells together and the response is registered.
//   The response is registered at commit, after the walk through the cell
//   chain; the next request is taken only once the table is back in idle, so
//   a new item is not accepted before the last one has committed.
//   A new request may be accepted while the previous response waits; if rsp
//   stalls, the finished item holds before commit until the output frees up.
//   Reset (rst, synchronous) marks every slot free and drops any item in
//   flight; slot contents are not cleared.
module sorted_address_region_table
  import srt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  srt_in_if.sink    req,
  srt_out_if.source rsp
);

  token_t  tok [TABLE_DEPTH+1];
  query_t  q;
  commit_t c;

  srt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .tok_last  (tok[TABLE_DEPTH]),
    .tok_first (tok[0]),
    .q         (q),
    .c         (c)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    srt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (SLOT_W'(i)),
      .q       (q),
      .c       (c),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

endmodule

// ----- verif/srt_region_checker.sv -----
// Scoreboard for sorted_address_region_table: keeps its own copy of the region table,
// predicts one response per accepted request and compares the responses in order.
// Depends on srt_pkg, srt_in_if and srt_out_if.
`timescale 1ns / 1ps

module srt_region_checker
  import srt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  srt_in_if           req,
  srt_out_if          rsp,
  output int unsigned errors,
  output int unsigned outstanding
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] addr;
    logic [63:0] length;
    logic [63:0] query_end;
    logic [63:0] offset;
    logic [3:0]  slot;
  } table_op_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  slot;
    logic [63:0] r_start;
    logic [63:0] r_end;
    logic [63:0] r_offset;
  } table_rsp_t;

  logic        live     [TABLE_DEPTH];
  logic [63:0] seg_start[TABLE_DEPTH];
  logic [63:0] seg_end  [TABLE_DEPTH];
  logic [63:0] seg_off  [TABLE_DEPTH];
  int          seg_rank [TABLE_DEPTH];

  table_rsp_t  rsp_due[$];

  function automatic table_rsp_t region_fields(int s);
    table_rsp_t r;
    r.status   = ST_OK;
    r.slot     = 4'(s);
    r.r_start  = seg_start[s];
    r.r_end    = seg_end[s];
    r.r_offset = seg_off[s];
    return r;
  endfunction

  // Updates the table copy and returns the response the block owes for op.
  function automatic table_rsp_t apply_table_op(table_op_t op);
    table_rsp_t r;
    int         free_slot;
    int         pos;
    int         s;
    int         pick;
    logic       hit;
    r        = '0;
    r.status = ST_NONE;
    case (op.kind)
      K_INSERT: begin
        free_slot = -1;
        for (int i = 0; i < TABLE_DEPTH; i++)
          if (!live[i] && free_slot < 0) free_slot = i;
        if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          // equal starts: the new region goes ahead of the older ones
          pos = 0;
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (live[i] && seg_start[i] < op.addr) pos++;
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (live[i] && seg_rank[i] >= pos) seg_rank[i]++;
          live[free_slot]      = 1'b1;
          seg_start[free_slot] = op.addr;
          seg_end[free_slot]   = op.addr + op.length;
          seg_off[free_slot]   = op.offset;
          seg_rank[free_slot]  = pos;
          r = region_fields(free_slot);
        end
      end
      K_REMOVE: begin
        s = int'(op.slot);
        if (s < TABLE_DEPTH && live[s]) begin
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (live[i] && seg_rank[i] > seg_rank[s]) seg_rank[i]--;
          live[s] = 1'b0;
          r = region_fields(s);
        end
      end
      K_CONTAIN, K_OVERLAP, K_OFFSET: begin
        pick = -1;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (op.kind == K_CONTAIN)
            hit = op.addr >= seg_start[i] && op.addr < seg_end[i];
          else if (op.kind == K_OVERLAP)
            hit = op.addr < seg_end[i] && op.query_end > seg_start[i];
          else
            hit = seg_off[i] == op.offset;
          if (live[i] && hit && (pick < 0 || seg_rank[i] < seg_rank[pick])) pick = i;
        end
        if (pick >= 0) r = region_fields(pick);
      end
      K_CLEAR: begin
        for (int i = 0; i < TABLE_DEPTH; i++) live[i] = 1'b0;
        r.status = ST_OK;
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  always @(posedge clk) begin
    table_op_t  op;
    table_rsp_t want;
    table_rsp_t got;
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) live[i] = 1'b0;
      rsp_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.status   = status_t'(rsp.status);
        got.slot     = rsp.slot_out;
        got.r_start  = rsp.region_start;
        got.r_end    = rsp.region_end;
        got.r_offset = rsp.region_offset_out;
        if (rsp_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: response with no request pending: status %0d slot %0d",
                     $time, got.status, got.slot);
        end else begin
          want = rsp_due.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.r_start !== want.r_start || got.r_end !== want.r_end ||
              got.r_offset !== want.r_offset) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
              $display("%0t: expected status %0d slot %0d start %h end %h offset %h",
                       $time, want.status, want.slot, want.r_start, want.r_end,
                       want.r_offset);
              $display("%0t:      got status %0d slot %0d start %h end %h offset %h",
                       $time, got.status, got.slot, got.r_start, got.r_end,
                       got.r_offset);
            end
          end
        end
      end
      if (req.valid && req.ready) begin
        op.kind      = req.kind;
        op.addr      = req.addr;
        op.length    = req.length;
        op.query_end = req.query_end;
        op.offset    = req.region_offset_in;
        op.slot      = req.slot_in;
        rsp_due.push_back(apply_table_op(op));
      end
    end
    outstanding = rsp_due.size();
  end

endmodule

// ----- verif/sorted_address_region_table_tb.sv -----
// Testbench top for sorted_address_region_table: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict. Checking lives in srt_region_checker.
// Depends on srt_pkg, srt_in_if, srt_out_if, srt_region_checker and the block itself.
`timescale 1ns / 1ps

module sorted_address_region_table_tb;
  import srt_pkg::*;

  localparam int          STALL_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          PHASE_ITEMS  = 470;
  localparam logic [2:0]  K_RSVD_6     = 3'd6;
  localparam logic [2:0]  K_RSVD_7     = 3'd7;
  localparam logic [63:0] BASE         = 64'h0000_1000_0000_0000;

  logic        clk;
  logic        rst;
  int unsigned errors;
  int unsigned outstanding;
  int unsigned src_idle;
  int unsigned sink_stall;
  logic [63:0] start_pool[8];
  logic [63:0] off_pool[8];

  srt_in_if  req_ch ();
  srt_out_if rsp_ch ();

  sorted_address_region_table u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  srt_region_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue_op(input logic [2:0] kind, input logic [63:0] addr,
                          input logic [63:0] len, input logic [63:0] qend,
                          input logic [63:0] off, input logic [3:0] slot);
    while ($urandom_range(99) < src_idle) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid            = 1'b1;
    req_ch.kind             = kind;
    req_ch.addr             = addr;
    req_ch.length           = len;
    req_ch.query_end        = qend;
    req_ch.region_offset_in = off;
    req_ch.slot_in          = slot;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly pooled addresses and offsets so that finds hit and starts collide.
  task automatic issue_random_op();
    logic [2:0]  kind;
    logic [63:0] addr;
    logic [63:0] len;
    logic [63:0] qend;
    logic [63:0] off;
    int          pick;
    addr = {$urandom, $urandom};
    len  = {$urandom, $urandom};
    qend = {$urandom, $urandom};
    off  = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 35)      kind = K_INSERT;
    else if (pick < 60) kind = K_REMOVE;
    else if (pick < 72) kind = K_CONTAIN;
    else if (pick < 84) kind = K_OVERLAP;
    else if (pick < 94) kind = K_OFFSET;
    else if (pick < 96) kind = K_CLEAR;
    else                kind = ($urandom_range(1) == 0) ? K_RSVD_6 : K_RSVD_7;
    if (kind == K_INSERT || kind == K_CONTAIN || kind == K_OVERLAP) begin
      case ($urandom_range(9))
        0:       addr = '0;
        1:       addr = '1;
        2:       ;
        default: addr = start_pool[$urandom_range(7)] +
                        (($urandom_range(1) == 0) ? 64'd0 : 64'($urandom_range('h1fff)));
      endcase
      case ($urandom_range(7))
        0:       len = '0;
        1:       len = '1;
        2:       ;
        default: len = 64'($urandom_range(1, 'h2000));
      endcase
      case ($urandom_range(5))
        0:       qend = '0;
        1:       qend = '1;
        2:       ;
        default: qend = addr + 64'($urandom_range('h2000));
      endcase
    end
    if ((kind == K_INSERT || kind == K_OFFSET) && $urandom_range(3) != 0)
      off = off_pool[$urandom_range(7)];
    issue_op(kind, addr, len, qend, off, 4'($urandom_range(15)));
  endtask

  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ch.ready = ($urandom_range(99) >= sink_stall);
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        stuck = 0;
      else
        stuck++;
    end
    $display("sorted_address_region_table: mismatch");
    $finish;
  end

  initial begin
    rst                     = 1'b1;
    src_idle                = 0;
    sink_stall              = 0;
    req_ch.valid            = 1'b0;
    req_ch.kind             = K_INSERT;
    req_ch.addr             = '0;
    req_ch.length           = '0;
    req_ch.query_end        = '0;
    req_ch.region_offset_in = '0;
    req_ch.slot_in          = '0;
    for (int k = 0; k < 8; k++) begin
      start_pool[k] = BASE + 64'(k) * 64'h800;
      off_pool[k]   = (k < 4) ? 64'(k) * 64'h1000 : {$urandom, $urandom};
    end
    start_pool[6] = 64'hffff_ffff_ffff_f000;
    start_pool[7] = {$urandom, $urandom};
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // directed: empty table, equal starts, wrapped and zero-length regions
    issue_op(K_CONTAIN, BASE, '0, '0, '0, 4'd0);
    issue_op(K_REMOVE, '0, '0, '0, '0, 4'd0);
    issue_op(K_OFFSET, '0, '0, '0, '0, 4'd0);
    issue_op(K_INSERT, BASE, 64'h100, '0, 64'ha0, 4'd0);
    issue_op(K_INSERT, BASE, 64'h200, '0, 64'hb0, 4'd0);
    issue_op(K_CONTAIN, BASE + 64'h80, '0, '0, '0, 4'd0);
    issue_op(K_CONTAIN, BASE + 64'h180, '0, '0, '0, 4'd0);
    issue_op(K_INSERT, '1, 64'd2, '0, '1, 4'd0);
    issue_op(K_CONTAIN, '1, '0, '0, '0, 4'd0);
    issue_op(K_INSERT, '0, '0, '0, '0, 4'd0);
    issue_op(K_CONTAIN, '0, '0, '0, '0, 4'd0);
    issue_op(K_OVERLAP, '0, '0, '1, '0, 4'd0);
    issue_op(K_OVERLAP, BASE + 64'h100, '0, BASE + 64'h101, '0, 4'd0);
    issue_op(K_OFFSET, '0, '0, '0, 64'ha0, 4'd0);
    issue_op(K_INSERT, '1, '1, '0, 64'h5a5a_a5a5_5a5a_a5a5, 4'd0);
    issue_op(K_OFFSET, '0, '0, '0, '1, 4'd0);
    issue_op(K_REMOVE, '0, '0, '0, '0, 4'd1);
    issue_op(K_REMOVE, '0, '0, '0, '0, 4'd1);
    issue_op(K_REMOVE, '0, '0, '0, '0, 4'd15);
    issue_op(K_RSVD_6, BASE, 64'h10, '0, '0, 4'd0);
    issue_op(K_RSVD_7, BASE, 64'h10, '0, '0, 4'd0);
    issue_op(K_CLEAR, '0, '0, '0, '0, 4'd0);
    issue_op(K_CONTAIN, BASE + 64'h80, '0, '0, '0, 4'd0);
    issue_op(K_INSERT, BASE, 64'h40, '0, 64'ha0, 4'd0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin src_idle = 0;  sink_stall = 0;  end
        1:       begin src_idle = 83; sink_stall = 0;  end
        2:       begin src_idle = 0;  sink_stall = 83; end
        default: begin src_idle = 20; sink_stall = 20; end
      endcase
      repeat (PHASE_ITEMS) issue_random_op();
    end
    req_ch.valid = 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0)
      $display("sorted_address_region_table: match");
    else
      $display("sorted_address_region_table: mismatch");
    $finish;
  end

endmodule
